[hw/rtl/bup_pkg.sv]
// ----------------------------------------------------------------------------
// bup_pkg
// Shared types, constants and helpers of the bilinear upscaler.
// ----------------------------------------------------------------------------
package bup_pkg;

  localparam int MAX_SOURCE_WIDTH  = 256;
  localparam int MAX_SOURCE_HEIGHT = 256;
  localparam int MAX_TARGET_WIDTH  = 2048;
  localparam int MAX_TARGET_HEIGHT = 2048;

  localparam int SW_W    = 9;
  localparam int TW_W    = 12;
  localparam int ADDR_W  = 16;
  localparam int DEPTH   = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ACC_W   = 19;
  localparam int POS_W   = 11;
  localparam int WGT_W   = 7;
  localparam int CNT_W   = 5;
  localparam int ARITH_W = 18;

  // reciprocal of one hundred, exact for magnitudes below about 91000
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam int RECIP_SH = 23;
  localparam logic [6:0] WEIGHT_ONE = 7'd100;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EMIT    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_ADDR,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [TW_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quotient;
    logic [TW_W-1:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]       n1;
    logic [7:0]       n2;
    logic [7:0]       n3;
    logic [7:0]       n4;
    logic [WGT_W-1:0] dx;
    logic [WGT_W-1:0] dy;
  } lane_in_t;

  // division by one hundred truncating toward zero
  function automatic logic signed [ARITH_W-1:0] trunc100(logic signed [ARITH_W-1:0] v);
    logic [ARITH_W-1:0] mag;
    logic [ARITH_W+16:0] prod;
    logic [ARITH_W-1:0] q;
    mag  = v[ARITH_W-1] ? ARITH_W'(-v) : ARITH_W'(v);
    prod = {17'b0, mag} * {{ARITH_W{1'b0}}, RECIP_100};
    q    = ARITH_W'(prod >> RECIP_SH);
    return v[ARITH_W-1] ? $signed(-q) : $signed(q);
  endfunction

endpackage

[hw/rtl/bup_if.sv]
// ----------------------------------------------------------------------------
// bup_in_if / bup_out_if
// Valid/ready channels of the upscaler.
// ----------------------------------------------------------------------------
interface bup_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] pixel_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;

  modport source (output valid, opcode, pixel_index, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, opcode, pixel_index, red_in, green_in, blue_in,
                  output ready);
endinterface

interface bup_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last,
                  output ready);
endinterface

[hw/rtl/bup_div.sv]
// ----------------------------------------------------------------------------
// bup_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bup_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bup_pkg::div_req_t  req_i,
  output bup_pkg::div_rsp_t  rsp_o
);
  import bup_pkg::*;

  logic [ACC_W-1:0] shift_q, shift_d;
  logic [TW_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [TW_W:0]    trial;

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    trial   = {rem_q, shift_q[ACC_W-1]};
    if (req_i.start) begin
      shift_d = req_i.dividend;
      rem_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, req_i.divisor}) begin
        rem_d   = TW_W'(trial - {1'b0, req_i.divisor});
        shift_d = {shift_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_d   = trial[TW_W-1:0];
        shift_d = {shift_q[ACC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ACC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = shift_q;
  assign rsp_o.remainder = rem_q;

endmodule

[hw/rtl/bup_lane.sv]
// ----------------------------------------------------------------------------
// bup_lane
// Four-stage blend of one color channel with hundredth weights.
// ----------------------------------------------------------------------------
module bup_lane (
  input  logic              clk_i,
  input  bup_pkg::lane_in_t lane_i,
  output logic [7:0]        chan_o
);
  import bup_pkg::*;

  logic signed [ARITH_W-1:0] a, b, c, d, wx, wy;
  logic signed [ARITH_W-1:0] p_q, q_q, ti_q, tq_q, m_q, a1_q, a2_q, b1_q, a3_q;
  logic [WGT_W-1:0]          dx1_q, dx2_q;
  logic signed [ARITH_W-1:0] sum4;
  logic [7:0]                chan_q;

  assign a  = $signed({10'b0, lane_i.n1});
  assign b  = $signed({10'b0, lane_i.n2});
  assign c  = $signed({10'b0, lane_i.n3});
  assign d  = $signed({10'b0, lane_i.n4});
  assign wy = $signed({11'b0, lane_i.dy});
  assign wx = $signed({11'b0, dx2_q});

  assign sum4 = trunc100(m_q) + tq_q + a3_q;

  always_ff @(posedge clk_i) begin
    // stage 1: weighted differences
    p_q   <= ARITH_W'(wy * (a + d - b - c));
    q_q   <= ARITH_W'(wy * (c - a));
    a1_q  <= a;
    b1_q  <= b;
    dx1_q <= lane_i.dx;
    // stage 2: first truncation
    ti_q  <= trunc100(p_q) + b1_q - a1_q;
    tq_q  <= trunc100(q_q);
    a2_q  <= a1_q;
    dx2_q <= dx1_q;
    // stage 3: horizontal weight
    m_q   <= ARITH_W'(wx * ti_q);
    a3_q  <= a2_q;
    // stage 4: final sum and saturation
    if (sum4 < 0) begin
      chan_q <= 8'd0;
    end else if (sum4 > 255) begin
      chan_q <= 8'd255;
    end else begin
      chan_q <= sum4[7:0];
    end
  end

  assign chan_o = chan_q;

endmodule

[hw/rtl/bilinear_upscale_hundredths.sv]
// ----------------------------------------------------------------------------
// bilinear_upscale_hundredths
// RGB bilinear upscaler with frame store and exact rational position step.
// ----------------------------------------------------------------------------
// channel   dir  carries
// in_req_i  in   opcode, pixel_index, red_in, green_in, blue_in
// out_res_o out  red_out, green_out, blue_out, frame_last
// cfg_*     in   register writes, index 0..3
//
// a load, restart or unused opcode is taken in the idle state; an emit holds the input
// through a go state and a wait state for each of the two passes of the
// position dividers, an address state, the read states RD1 to RD3 of the two-port
// frame store, the blend state of the channel lanes and the output state
// the result is registered in the output state
// reset clears control state only; the frame store is undefined until loaded
// a result waiting on out_res_o stalls the next emit in its output state, and
// all requests with it, as requests are taken only in the idle state
module bilinear_upscale_hundredths (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  bup_in_if.sink      in_req_i,
  bup_out_if.source   out_res_o
);
  import bup_pkg::*;

  state_e state_q, state_d;

  logic [SW_W-1:0]   src_w_q, src_h_q;
  logic [TW_W-1:0]   dst_w_q, dst_h_q;
  logic [POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [ACC_W-1:0]  cacc_q, cacc_d, racc_q, racc_d;

  logic [23:0]       mem [DEPTH];
  logic [ADDR_W-1:0] ra0, ra1;
  logic [23:0]       rd0_q, rd1_q;
  logic [23:0]       px1_q, px2_q, px3_q, px4_q;

  div_req_t          creq, rreq;
  div_rsp_t          crsp, rrsp;
  logic              div_go, div_pass2;

  logic [ACC_W-1:0]  qc_q, qr_q;
  logic [TW_W-1:0]   remc_q, remr_q;
  logic [WGT_W-1:0]  dx_q, dy_q;
  logic [ADDR_W-1:0] a1_q, a2_q, a3_q, a4_q;
  logic [2:0]        wait_q, wait_d;

  logic [TW_W-1:0]   wden, hden;
  logic [7:0]        lastc, lastr, c1, r1, c2, r2;
  logic [16:0]       rowb1, rowb2;

  lane_in_t          lane_r, lane_g, lane_b;
  logic [7:0]        chan_r, chan_g, chan_b;

  logic              in_acc, out_load, out_valid_q, row_end, frame_end;
  logic [7:0]        red_q, green_q, blue_q;
  logic              last_q;

  logic [SW_W-1:0]   cfg_s;
  logic [TW_W-1:0]   cfg_t;

  // register writes, clamped to the legal range
  always_comb begin
    cfg_s = cfg_data_i[SW_W-1:0];
    if (cfg_s < SW_W'(2)) begin
      cfg_s = SW_W'(2);
    end else if (cfg_s > SW_W'(MAX_SOURCE_WIDTH)) begin
      cfg_s = SW_W'(MAX_SOURCE_WIDTH);
    end
    cfg_t = cfg_data_i;
    if (cfg_t < TW_W'(2)) begin
      cfg_t = TW_W'(2);
    end else if (cfg_t > TW_W'(MAX_TARGET_WIDTH)) begin
      cfg_t = TW_W'(MAX_TARGET_WIDTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SW_W'(256);
      src_h_q <= SW_W'(256);
      dst_w_q <= TW_W'(1920);
      dst_h_q <= TW_W'(1080);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SRC_W: src_w_q <= cfg_s;
        REG_SRC_H: src_h_q <= (cfg_s > SW_W'(MAX_SOURCE_HEIGHT)) ?
                              SW_W'(MAX_SOURCE_HEIGHT) : cfg_s;
        REG_DST_W: dst_w_q <= cfg_t;
        REG_DST_H: dst_h_q <= (cfg_t > TW_W'(MAX_TARGET_HEIGHT)) ?
                              TW_W'(MAX_TARGET_HEIGHT) : cfg_t;
        default:   ;
      endcase
    end
  end

  assign wden  = dst_w_q - 1'b1;
  assign hden  = dst_h_q - 1'b1;
  assign lastc = 8'(src_w_q - 1'b1);
  assign lastr = 8'(src_h_q - 1'b1);

  assign in_acc = in_req_i.valid && in_req_i.ready;

  // position dividers, integer part first, then the hundredths
  assign creq.start    = div_go;
  assign creq.divisor  = wden;
  assign creq.dividend = div_pass2 ? ACC_W'(remc_q * WEIGHT_ONE) : cacc_q;
  assign rreq.start    = div_go;
  assign rreq.divisor  = hden;
  assign rreq.dividend = div_pass2 ? ACC_W'(remr_q * WEIGHT_ONE) : racc_q;

  bup_div u_div_col (.clk_i, .rst_ni, .req_i(creq), .rsp_o(crsp));
  bup_div u_div_row (.clk_i, .rst_ni, .req_i(rreq), .rsp_o(rrsp));

  // neighbor coordinates, clamped to the last column and row
  always_comb begin
    c1 = (qc_q > ACC_W'(lastc)) ? lastc : qc_q[7:0];
    r1 = (qr_q > ACC_W'(lastr)) ? lastr : qr_q[7:0];
    c2 = (c1 < lastc) ? c1 + 1'b1 : lastc;
    r2 = (r1 < lastr) ? r1 + 1'b1 : lastr;
    rowb1 = r1 * src_w_q;
    rowb2 = r2 * src_w_q;
  end

  // frame store, one write and two reads a cycle
  assign ra0 = (state_q == ST_RD1) ? a1_q : a3_q;
  assign ra1 = (state_q == ST_RD1) ? a2_q : a4_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_e'(in_req_i.opcode) == OP_LOAD) begin
      mem[in_req_i.pixel_index] <= {in_req_i.red_in, in_req_i.green_in,
                                    in_req_i.blue_in};
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV1_WAIT && crsp.done) begin
      qc_q   <= crsp.quotient;
      remc_q <= crsp.remainder;
      qr_q   <= rrsp.quotient;
      remr_q <= rrsp.remainder;
    end
    if (state_q == ST_DIV2_WAIT && crsp.done) begin
      dx_q <= crsp.quotient[WGT_W-1:0];
      dy_q <= rrsp.quotient[WGT_W-1:0];
    end
    if (state_q == ST_ADDR) begin
      a1_q <= ADDR_W'(rowb1 + 17'(c1));
      a2_q <= ADDR_W'(rowb1 + 17'(c2));
      a3_q <= ADDR_W'(rowb2 + 17'(c1));
      a4_q <= ADDR_W'(rowb2 + 17'(c2));
    end
    if (state_q == ST_RD2) begin
      px1_q <= rd0_q;
      px2_q <= rd1_q;
    end
    if (state_q == ST_RD3) begin
      px3_q <= rd0_q;
      px4_q <= rd1_q;
    end
  end

  // one lane per color channel
  assign lane_r = '{n1: px1_q[23:16], n2: px2_q[23:16], n3: px3_q[23:16],
                    n4: px4_q[23:16], dx: dx_q, dy: dy_q};
  assign lane_g = '{n1: px1_q[15:8], n2: px2_q[15:8], n3: px3_q[15:8],
                    n4: px4_q[15:8], dx: dx_q, dy: dy_q};
  assign lane_b = '{n1: px1_q[7:0], n2: px2_q[7:0], n3: px3_q[7:0],
                    n4: px4_q[7:0], dx: dx_q, dy: dy_q};

  bup_lane u_lane_r (.clk_i, .lane_i(lane_r), .chan_o(chan_r));
  bup_lane u_lane_g (.clk_i, .lane_i(lane_g), .chan_o(chan_g));
  bup_lane u_lane_b (.clk_i, .lane_i(lane_b), .chan_o(chan_b));

  assign row_end   = {1'b0, col_q} >= wden;
  assign frame_end = row_end && ({1'b0, row_q} >= hden);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && opcode_e'(in_req_i.opcode) == OP_EMIT) state_d = ST_DIV1_GO;
      end
      ST_DIV1_GO:   state_d = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (crsp.done) state_d = ST_DIV2_GO;
      ST_DIV2_GO:   state_d = ST_DIV2_WAIT;
      ST_DIV2_WAIT: if (crsp.done) state_d = ST_ADDR;
      ST_ADDR:      state_d = ST_RD1;
      ST_RD1:       state_d = ST_RD2;
      ST_RD2:       state_d = ST_RD3;
      ST_RD3:       state_d = ST_BLEND;
      ST_BLEND:     if (wait_q == 3'd4) state_d = ST_OUT;
      ST_OUT:       if (!out_valid_q || out_res_o.ready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs and position update
  always_comb begin
    in_req_i.ready = (state_q == ST_IDLE);
    div_go    = (state_q == ST_DIV1_GO) || (state_q == ST_DIV2_GO);
    div_pass2 = (state_q == ST_DIV2_GO);
    out_load  = (state_q == ST_OUT) && (!out_valid_q || out_res_o.ready);
    wait_d    = (state_q == ST_BLEND) ? wait_q + 1'b1 : 3'd0;
    col_d  = col_q;
    row_d  = row_q;
    cacc_d = cacc_q;
    racc_d = racc_q;
    if (in_acc && opcode_e'(in_req_i.opcode) == OP_RESTART) begin
      col_d  = '0;
      row_d  = '0;
      cacc_d = '0;
      racc_d = '0;
    end else if (out_load) begin
      if (!row_end) begin
        col_d  = col_q + 1'b1;
        cacc_d = cacc_q + ACC_W'(lastc);
      end else begin
        col_d  = '0;
        cacc_d = '0;
        if (frame_end) begin
          row_d  = '0;
          racc_d = '0;
        end else begin
          row_d  = row_q + 1'b1;
          racc_d = racc_q + ACC_W'(lastr);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cacc_q      <= '0;
      racc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cacc_q  <= cacc_d;
      racc_q  <= racc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge of the lanes into the result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= chan_r;
      green_q <= chan_g;
      blue_q  <= chan_b;
      last_q  <= frame_end;
    end
  end

  assign out_res_o.valid      = out_valid_q;
  assign out_res_o.red_out    = red_q;
  assign out_res_o.green_out  = green_q;
  assign out_res_o.blue_out   = blue_q;
  assign out_res_o.frame_last = last_q;

endmodule
